/* rtl/core/scsa_pkg.sv */
`default_nettype none
package scsa_pkg;

  localparam int NUM_CLASSES    = 16;
  localparam int MAX_SLABS      = 64;
  localparam int SLOTS_PER_SLAB = 128;

  // Port widths, fixed by the interface
  localparam int SIZE_W       = 32;
  localparam int CLASS_PORT_W = 4;
  localparam int SLAB_PORT_W  = 6;
  localparam int SLOT_PORT_W  = 7;
  localparam int STATUS_W     = 3;

  // Internal widths
  localparam int CLASS_CALC_W = 6;  // holds ceil(log2) of a 32-bit size, up to 32
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLAB_W  = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int NSLAB_W = $clog2(MAX_SLABS + 1);
  localparam int SLOT_W  = $clog2(SLOTS_PER_SLAB);
  localparam int CNT_W   = $clog2(SLOTS_PER_SLAB + 1);
  localparam int ENTRIES = NUM_CLASSES * MAX_SLABS;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENTRY_W = CNT_W + SLOTS_PER_SLAB;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED    = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_OUT_OF_SLABS = 3'd2,
    ST_FREED        = 3'd3,
    ST_IGNORED      = 3'd4
  } status_t;

  // ceil(log2(size)); sizes 0 and 1 land in class 0
  function automatic logic [CLASS_CALC_W-1:0] size_class(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0]       v;
    logic [CLASS_CALC_W-1:0] n;
    v = size - SIZE_W'(1);
    n = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) n = CLASS_CALC_W'(i + 1);
    end
    if (size <= SIZE_W'(1)) n = '0;
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [SLAB_W-1:0] slab);
    return ADDR_W'(cls) * ADDR_W'(MAX_SLABS) + ADDR_W'(slab);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/scsa_ram.sv */
`default_nettype none
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/core/size_class_slab_allocator_top.sv */
// Size-class slab allocator with one bitmap of slots per slab.
// Input channel (in_valid/in_ready): func selects allocate or free. An allocate
// maps request_size to class ceil(log2(size)), searches that class's slabs from
// the newest down for the lowest free slot, and opens a new slab when none has
// room. A free names class, slab and slot and clears the slot if it is taken.
// Output channel (out_valid/out_ready): one result per request, in order;
// status, class_index, slab_index, slot_index (indexes are 0 unless allocated).
// One request is in work at a time. A free reads its slab entry and then
// clears the slot; a too-large allocate, and a free whose slab index is out of
// range, go straight to the result. An allocate reads one slab entry a cycle
// from the slab memory, which holds each slab's bitmap and slot count, newest
// slab first; it stops at the first slab with room, and opens a new slab after
// reading all created slabs (with no read when the class has none).
// A finished result sits in the output register; the next request is taken
// while it waits, and that request's result holds until out_ready frees it.
// Reset clears the per-class slab counters and out_valid, sets in_ready; the
// slab memory needs no clearing, since only entries of created slabs are read.
`default_nettype none
module size_class_slab_allocator_top
  import scsa_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    func,
  input  wire logic [SIZE_W-1:0]       request_size,
  input  wire logic [CLASS_PORT_W-1:0] free_class,
  input  wire logic [SLAB_PORT_W-1:0]  free_slab,
  input  wire logic [SLOT_PORT_W-1:0]  free_slot,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [STATUS_W-1:0]          status,
  output logic [CLASS_PORT_W-1:0]      class_index,
  output logic [SLAB_PORT_W-1:0]       slab_index,
  output logic [SLOT_PORT_W-1:0]       slot_index
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_COMMIT,
    S_NEW,
    S_FREE_CHK,
    S_DONE
  } state_t;

  function automatic logic [SLOT_W-1:0] onehot_index(input logic [SLOTS_PER_SLAB-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < SLOTS_PER_SLAB; i++) begin
      if (oh[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

  state_t state;

  logic                      func_q;
  logic [SIZE_W-1:0]         size_q;
  logic [CLASS_PORT_W-1:0]   fcls_q;
  logic [SLAB_PORT_W-1:0]    fslab_q;
  logic [SLOT_PORT_W-1:0]    fslot_q;

  logic [NSLAB_W-1:0]        created [NUM_CLASSES];
  logic [CLS_W-1:0]          cls;
  logic [NSLAB_W-1:0]        n_q;
  logic [NSLAB_W-1:0]        issue_k;
  logic                      rd_pending;
  logic [SLAB_W-1:0]         rd_slab;
  logic [SLAB_W-1:0]         hit_slab;
  logic [SLOTS_PER_SLAB-1:0] bm_q;
  logic [SLOTS_PER_SLAB-1:0] onehot_q;
  logic [CNT_W-1:0]          cnt_q;

  status_t                   res_status;
  logic [CLASS_PORT_W-1:0]   res_class;
  logic [SLAB_PORT_W-1:0]    res_slab;
  logic [SLOT_PORT_W-1:0]    res_slot;

  // Slab memory port signals
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ENTRY_W-1:0]        rd_data;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ENTRY_W-1:0]        wr_data;

  logic [SLOTS_PER_SLAB-1:0] rd_bm;
  logic [CNT_W-1:0]          rd_cnt;
  logic [CLASS_CALC_W-1:0]   req_class;
  logic [CLS_W-1:0]          req_cls;
  logic [CLS_W-1:0]          free_cls;
  logic [SLAB_W-1:0]         free_slb;
  logic [ADDR_W-1:0]         free_addr;
  logic                      free_ok;
  logic                      scan_hit;
  logic                      slot_taken;
  logic                      free_clear;
  logic [SLOTS_PER_SLAB-1:0] free_mask;

  scsa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_slab_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_bm     = rd_data[SLOTS_PER_SLAB-1:0];
  assign rd_cnt    = rd_data[ENTRY_W-1:SLOTS_PER_SLAB];
  assign req_class = size_class(size_q);
  assign req_cls   = CLS_W'(req_class);
  assign free_cls  = CLS_W'(fcls_q);
  assign free_slb  = SLAB_W'(fslab_q);
  assign free_addr = entry_addr(free_cls, free_slb);
  assign free_ok   = (32'(fcls_q) < NUM_CLASSES) &&
                     (32'(fslab_q) < 32'(created[free_cls])) &&
                     (32'(fslot_q) < SLOTS_PER_SLAB);
  // A slab is live while its count is nonzero; count below capacity means a free slot
  assign scan_hit  = rd_pending && (rd_cnt != '0) && (rd_cnt < CNT_W'(SLOTS_PER_SLAB));
  assign free_mask = SLOTS_PER_SLAB'(1) << fslot_q[SLOT_W-1:0];
  assign slot_taken = rd_bm[fslot_q[SLOT_W-1:0]];
  assign free_clear = (rd_cnt != '0) && slot_taken;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = free_addr;
    wr_en   = 1'b0;
    wr_addr = free_addr;
    wr_data = {rd_cnt - CNT_W'(1), rd_bm & ~free_mask};
    case (state)
      S_DECODE: begin
        rd_en = (func_q == FUNC_FREE) && free_ok;
      end
      S_SCAN: begin
        rd_en   = (issue_k != '0);
        rd_addr = entry_addr(cls, SLAB_W'(issue_k - NSLAB_W'(1)));
      end
      S_COMMIT: begin
        wr_en   = 1'b1;
        wr_addr = entry_addr(cls, hit_slab);
        wr_data = {cnt_q + CNT_W'(1), bm_q | onehot_q};
      end
      S_NEW: begin
        wr_en   = (n_q < NSLAB_W'(MAX_SLABS));
        wr_addr = entry_addr(cls, SLAB_W'(n_q));
        wr_data = {CNT_W'(1), SLOTS_PER_SLAB'(1)};
      end
      S_FREE_CHK: begin
        wr_en = free_clear;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rd_pending <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) created[i] <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q  <= func;
            size_q  <= request_size;
            fcls_q  <= free_class;
            fslab_q <= free_slab;
            fslot_q <= free_slot;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_class <= '0;
          res_slab  <= '0;
          res_slot  <= '0;
          if (func_q == FUNC_ALLOC) begin
            if (req_class >= CLASS_CALC_W'(NUM_CLASSES)) begin
              res_status <= ST_TOO_LARGE;
              state      <= S_DONE;
            end else begin
              cls        <= req_cls;
              n_q        <= created[req_cls];
              issue_k    <= created[req_cls];
              rd_pending <= 1'b0;
              state      <= S_SCAN;
            end
          end else if (free_ok) begin
            state <= S_FREE_CHK;
          end else begin
            res_status <= ST_IGNORED;
            state      <= S_DONE;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            bm_q     <= rd_bm;
            cnt_q    <= rd_cnt;
            onehot_q <= ~rd_bm & (rd_bm + SLOTS_PER_SLAB'(1));  // lowest clear bit
            hit_slab <= rd_slab;
            state    <= S_COMMIT;
          end else if (!rd_pending && issue_k == '0) begin
            state <= S_NEW;
          end else begin
            rd_pending <= (issue_k != '0);
            if (issue_k != '0) begin
              rd_slab <= SLAB_W'(issue_k - NSLAB_W'(1));
              issue_k <= issue_k - NSLAB_W'(1);
            end
          end
        end
        S_COMMIT: begin
          res_status <= ST_ALLOCATED;
          res_class  <= CLASS_PORT_W'(cls);
          res_slab   <= SLAB_PORT_W'(hit_slab);
          res_slot   <= SLOT_PORT_W'(onehot_index(onehot_q));
          state      <= S_DONE;
        end
        S_NEW: begin
          if (n_q < NSLAB_W'(MAX_SLABS)) begin
            created[cls] <= n_q + NSLAB_W'(1);
            res_status   <= ST_ALLOCATED;
            res_class    <= CLASS_PORT_W'(cls);
            res_slab     <= SLAB_PORT_W'(n_q);
          end else begin
            res_status <= ST_OUT_OF_SLABS;
          end
          state <= S_DONE;
        end
        S_FREE_CHK: begin
          res_status <= free_clear ? ST_FREED : ST_IGNORED;
          state      <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            class_index <= res_class;
            slab_index  <= res_slab;
            slot_index  <= res_slot;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
module tb;
  import scsa_pkg::*;

  typedef struct packed {
    status_t                 st;
    logic [CLASS_PORT_W-1:0] cls;
    logic [SLAB_PORT_W-1:0]  slab;
    logic [SLOT_PORT_W-1:0]  slot;
  } alloc_result_t;

  // One request; typed rows carry the result written out by hand
  typedef struct packed {
    logic                    f;
    logic [SIZE_W-1:0]       size;
    logic [CLASS_PORT_W-1:0] fcls;
    logic [SLAB_PORT_W-1:0]  fslab;
    logic [SLOT_PORT_W-1:0]  fslot;
    logic                    typed;
    alloc_result_t           known;
  } request_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    func = FUNC_ALLOC;
  logic [SIZE_W-1:0]       request_size = '0;
  logic [CLASS_PORT_W-1:0] free_class = '0;
  logic [SLAB_PORT_W-1:0]  free_slab = '0;
  logic [SLOT_PORT_W-1:0]  free_slot = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [STATUS_W-1:0]     status;
  logic [CLASS_PORT_W-1:0] class_index;
  logic [SLAB_PORT_W-1:0]  slab_index;
  logic [SLOT_PORT_W-1:0]  slot_index;

  size_class_slab_allocator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .request_size(request_size),
    .free_class(free_class), .free_slab(free_slab), .free_slot(free_slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .class_index(class_index),
    .slab_index(slab_index), .slot_index(slot_index)
  );

  always #5 clk = ~clk;

  // Allocator state as the testbench sees it
  logic [SLOTS_PER_SLAB-1:0] slab_bits  [NUM_CLASSES][MAX_SLABS];
  int                        slab_fill  [NUM_CLASSES][MAX_SLABS];
  bit                        slab_alive [NUM_CLASSES][MAX_SLABS];
  int                        slabs_made [NUM_CLASSES];

  alloc_result_t pending_results[$];
  alloc_result_t granted_blocks[$];
  request_t      plan[$];
  int            errors = 0;
  bit            send_quiet = 1'b0;
  bit            take_quiet = 1'b0;

  function automatic int class_of(logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] v;
    int n;
    n = 0;
    if (size > 1) begin
      v = size - 1;
      while (v != 0) begin
        n++;
        v = v >> 1;
      end
    end
    return n;
  endfunction

  function automatic alloc_result_t slab_alloc_free(request_t r);
    alloc_result_t res;
    int c, k, s;
    bit found;
    res = '0;
    found = 1'b0;
    if (r.f == FUNC_ALLOC) begin
      c = class_of(r.size);
      if (c >= NUM_CLASSES) begin
        res.st = ST_TOO_LARGE;
      end else begin
        // newest slab first, lowest free slot
        for (k = slabs_made[c] - 1; k >= 0 && !found; k--) begin
          if (slab_alive[c][k]) begin
            for (s = 0; s < SLOTS_PER_SLAB && !found; s++) begin
              if (!slab_bits[c][k][s]) begin
                slab_bits[c][k][s] = 1'b1;
                slab_fill[c][k]++;
                res.st   = ST_ALLOCATED;
                res.cls  = CLASS_PORT_W'(c);
                res.slab = SLAB_PORT_W'(k);
                res.slot = SLOT_PORT_W'(s);
                found = 1'b1;
              end
            end
          end
        end
        if (!found) begin
          if (slabs_made[c] >= MAX_SLABS) begin
            res.st = ST_OUT_OF_SLABS;
          end else begin
            k = slabs_made[c];
            slab_bits[c][k]  = SLOTS_PER_SLAB'(1);
            slab_fill[c][k]  = 1;
            slab_alive[c][k] = 1'b1;
            slabs_made[c]++;
            res.st   = ST_ALLOCATED;
            res.cls  = CLASS_PORT_W'(c);
            res.slab = SLAB_PORT_W'(k);
          end
        end
      end
    end else begin
      c = r.fcls;
      k = r.fslab;
      s = r.fslot;
      res.st = ST_IGNORED;
      if (c < NUM_CLASSES && k < slabs_made[c] && s < SLOTS_PER_SLAB) begin
        if (slab_alive[c][k] && slab_bits[c][k][s]) begin
          slab_bits[c][k][s] = 1'b0;
          slab_fill[c][k]--;
          if (slab_fill[c][k] == 0) slab_alive[c][k] = 1'b0;
          res.st = ST_FREED;
        end
      end
    end
    return res;
  endfunction

  function automatic request_t alloc_req(logic [SIZE_W-1:0] size);
    request_t r;
    r = '0;
    r.f = FUNC_ALLOC;
    r.size = size;
    return r;
  endfunction

  function automatic request_t free_req(int c, int sb, int so);
    request_t r;
    r = '0;
    r.f = FUNC_FREE;
    r.fcls = CLASS_PORT_W'(c);
    r.fslab = SLAB_PORT_W'(sb);
    r.fslot = SLOT_PORT_W'(so);
    return r;
  endfunction

  function automatic request_t expecting(request_t r, status_t st, int c, int sb, int so);
    r.typed = 1'b1;
    r.known.st = st;
    r.known.cls = CLASS_PORT_W'(c);
    r.known.slab = SLAB_PORT_W'(sb);
    r.known.slot = SLOT_PORT_W'(so);
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] size_in_class(int c);
    if (c == 0) return $urandom_range(0, 1);
    return (SIZE_W'(1) << (c - 1)) + 1 + $urandom_range(0, (1 << (c - 1)) - 1);
  endfunction

  function automatic int pick_class();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 3);
    return $urandom_range(0, NUM_CLASSES - 1);
  endfunction

  task automatic issue(input request_t r, output alloc_result_t got);
    int gap;
    alloc_result_t want;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= r.f;
    request_size <= r.size;
    free_class   <= r.fcls;
    free_slab    <= r.fslab;
    free_slot    <= r.fslot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = slab_alloc_free(r);
    want = r.typed ? r.known : got;
    pending_results.push_back(want);
    if (got.st == ST_ALLOCATED) granted_blocks.push_back(got);
  endtask

  initial begin : drain_results
    int stall;
    alloc_result_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = take_quiet ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        errors++;
        $error("result transfer with nothing pending: status %0d", status);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          errors++;
          $error("status expected %0d actual %0d", want.st, status);
        end
        if (class_index !== want.cls) begin
          errors++;
          $error("class_index expected %0d actual %0d", want.cls, class_index);
        end
        if (slab_index !== want.slab) begin
          errors++;
          $error("slab_index expected %0d actual %0d", want.slab, slab_index);
        end
        if (slot_index !== want.slot) begin
          errors++;
          $error("slot_index expected %0d actual %0d", want.slot, slot_index);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    alloc_result_t g, b;
    int c, len, pick, idx, counted;
    counted = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(expecting(alloc_req(0), ST_ALLOCATED, 0, 0, 0));
    plan.push_back(expecting(alloc_req(1), ST_ALLOCATED, 0, 0, 1));
    plan.push_back(expecting(alloc_req(2), ST_ALLOCATED, 1, 0, 0));
    plan.push_back(expecting(alloc_req(32'd32768), ST_ALLOCATED, 15, 0, 0));
    plan.push_back(expecting(alloc_req(32'd32769), ST_TOO_LARGE, 0, 0, 0));
    plan.push_back(expecting(alloc_req(32'hFFFF_FFFF), ST_TOO_LARGE, 0, 0, 0));
    plan.push_back(expecting(alloc_req(32'h8000_0000), ST_TOO_LARGE, 0, 0, 0));
    plan.push_back(alloc_req(3));
    plan.push_back(alloc_req(4));
    plan.push_back(alloc_req(5));
    plan.push_back(expecting(free_req(0, 0, 1), ST_FREED, 0, 0, 0));
    // slot already clear
    plan.push_back(expecting(free_req(0, 0, 1), ST_IGNORED, 0, 0, 0));
    // slab never created
    plan.push_back(expecting(free_req(7, 0, 0), ST_IGNORED, 0, 0, 0));
    plan.push_back(expecting(free_req(15, 63, 127), ST_IGNORED, 0, 0, 0));
    plan.push_back(expecting(free_req(15, 0, 127), ST_IGNORED, 0, 0, 0));
    // last slot of the slab: the slab dies, then the same free hits a dead slab
    plan.push_back(expecting(free_req(1, 0, 0), ST_FREED, 0, 0, 0));
    plan.push_back(expecting(free_req(1, 0, 0), ST_IGNORED, 0, 0, 0));
    plan.push_back(alloc_req(2));
    plan.push_back(alloc_req(0));
    plan.push_back(free_req(0, 0, 0));
    plan.push_back(free_req(0, 0, 1));
    plan.push_back(alloc_req(1));
    plan.push_back(expecting(alloc_req(32'd65536), ST_TOO_LARGE, 0, 0, 0));
    plan.push_back(expecting(alloc_req(32'h7FFF_FFFF), ST_TOO_LARGE, 0, 0, 0));
    foreach (plan[i]) issue(plan[i], g);

    while (counted < 1700) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        // long bursts fill a slab and spill into new ones
        c = pick_class();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 30);
        repeat (len) begin
          issue(alloc_req(size_in_class(c)), g);
          counted++;
        end
      end else if (pick <= 6) begin
        len = $urandom_range(1, 30);
        repeat (len) begin
          if (granted_blocks.size() != 0) begin
            idx = $urandom_range(0, granted_blocks.size() - 1);
            b = granted_blocks[idx];
            granted_blocks.delete(idx);
            issue(free_req(b.cls, b.slab, b.slot), g);
            if (g.st != ST_IGNORED) counted++;
          end
        end
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 4)) begin
          issue(free_req($urandom_range(0, 15), $urandom_range(0, 63),
                         $urandom_range(0, 127)), g);
          if (g.st != ST_IGNORED) counted++;
        end
      end else if (pick == 8) begin
        issue(alloc_req($urandom), g);
        counted++;
      end else begin
        repeat ($urandom_range(5, 30)) begin
          if ($urandom_range(0, 1) == 0 || granted_blocks.size() == 0) begin
            issue(alloc_req(size_in_class(pick_class())), g);
            counted++;
          end else begin
            idx = $urandom_range(0, granted_blocks.size() - 1);
            b = granted_blocks[idx];
            granted_blocks.delete(idx);
            issue(free_req(b.cls, b.slab, b.slot), g);
            if (g.st != ST_IGNORED) counted++;
          end
        end
      end
    end

    // Use up every slab index of one class: empty it, then create and kill
    // slabs until the limit, then ask once more and free slot 0 of the last slab.
    c = $urandom_range(0, NUM_CLASSES - 1);
    for (idx = granted_blocks.size() - 1; idx >= 0; idx--) begin
      if (granted_blocks[idx].cls == c) begin
        b = granted_blocks[idx];
        granted_blocks.delete(idx);
        issue(free_req(b.cls, b.slab, b.slot), g);
      end
    end
    while (slabs_made[c] < MAX_SLABS) begin
      issue(alloc_req(size_in_class(c)), g);
      if (g.st == ST_ALLOCATED) begin
        b = granted_blocks.pop_back();
        issue(free_req(b.cls, b.slab, b.slot), g);
      end
    end
    issue(alloc_req(size_in_class(c)), g);
    issue(free_req(c, MAX_SLABS - 1, 0), g);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/scsa_pkg.sv
rtl/core/scsa_ram.sv
rtl/core/size_class_slab_allocator_top.sv
sim/tb.sv
